// ===== sv/clc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, register codes and the configuration bundle for the
// cache lookup core. No dependencies.
package clc_pkg;

  localparam int ADDR_W              = 32;
  localparam int TAG_W               = 30;
  localparam int TOT_W               = 32;
  localparam int CFG_W               = 4;
  localparam int CFG_IDX_W           = 2;
  localparam int QUEUE_DEPTH         = 2;
  localparam int DEF_MAX_INDEX_BITS  = 10;
  localparam int DEF_MAX_WAYS        = 8;
  localparam int MIN_OFFSET_BITS     = 2;
  localparam int MAX_OFFSET_BITS     = 8;

  localparam logic [CFG_W-1:0] RST_INDEX_BITS  = 4'd10;
  localparam logic [CFG_W-1:0] RST_OFFSET_BITS = 4'd2;
  localparam logic [CFG_W-1:0] RST_WAYS        = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INDEX_BITS  = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_WAYS        = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] index_bits;
    logic [CFG_W-1:0] block_offset_bits;
    logic [CFG_W-1:0] ways;
  } cfg_t;

endpackage

// ===== sv/clc_front.sv =====
`timescale 1ns / 1ps
// Front end: splits an incoming address into set index and tag.
// Depends on clc_pkg.
module clc_front #(
  parameter int MAX_INDEX_BITS = clc_pkg::DEF_MAX_INDEX_BITS,
  localparam int SET_W = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1
) (
  input  logic [clc_pkg::ADDR_W-1:0] address,
  input  clc_pkg::cfg_t              cfg,
  output logic [SET_W-1:0]           set_idx,
  output logic [clc_pkg::TAG_W-1:0]  tag
);
  import clc_pkg::*;

  logic [CFG_W-1:0]  ib;
  logic [CFG_W-1:0]  ob;
  logic [CFG_W:0]    tag_shift;
  logic [ADDR_W-1:0] set_sh;
  logic [ADDR_W-1:0] tag_sh;
  logic [SET_W-1:0]  mask;

  always_comb begin
    // clamp the index and offset widths into their legal ranges
    ib = (int'(cfg.index_bits) > MAX_INDEX_BITS) ? CFG_W'(MAX_INDEX_BITS) : cfg.index_bits;
    if (int'(cfg.block_offset_bits) < MIN_OFFSET_BITS) begin
      ob = CFG_W'(MIN_OFFSET_BITS);
    end else if (int'(cfg.block_offset_bits) > MAX_OFFSET_BITS) begin
      ob = CFG_W'(MAX_OFFSET_BITS);
    end else begin
      ob = cfg.block_offset_bits;
    end
    tag_shift = {1'b0, ib} + {1'b0, ob};
    set_sh    = address >> ob;
    tag_sh    = address >> tag_shift;
    mask      = ~({SET_W{1'b1}} << ib);
    set_idx   = set_sh[SET_W-1:0] & mask;
    tag       = tag_sh[TAG_W-1:0];
  end

endmodule

// ===== sv/clc_fifo.sv =====
`timescale 1ns / 1ps
// Small register queue used between front and back and on the result side.
// Depends on clc_pkg for its default depth.
module clc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = clc_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  import clc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== sv/clc_back.sv =====
`timescale 1ns / 1ps
// Back end: set memory, read-modify-write of the LRU order, hit/miss totals
// and the clearing sweep after reset. Depends on clc_pkg.
module clc_back #(
  parameter int MAX_INDEX_BITS = clc_pkg::DEF_MAX_INDEX_BITS,
  parameter int MAX_WAYS       = clc_pkg::DEF_MAX_WAYS,
  localparam int SET_W = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [clc_pkg::CFG_W-1:0]  cfg_ways,
  input  logic                       mid_empty,
  input  logic [SET_W-1:0]           mid_set,
  input  logic [clc_pkg::TAG_W-1:0]  mid_tag,
  output logic                       mid_pop,
  input  logic                       res_full,
  output logic                       res_push,
  output logic                       res_hit,
  output logic [SET_W-1:0]           res_set,
  output logic [clc_pkg::TAG_W-1:0]  res_tag,
  output logic [clc_pkg::TOT_W-1:0]  res_hit_tot,
  output logic [clc_pkg::TOT_W-1:0]  res_miss_tot,
  output logic                       clearing
);
  import clc_pkg::*;

  localparam int SETS  = 1 << MAX_INDEX_BITS;
  localparam int CNT_W = $clog2(MAX_WAYS + 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_UPD} state_t;
  typedef logic [MAX_WAYS-1:0][TAG_W-1:0] row_t;

  // one row per set: tags in LRU order plus the count of valid ways
  row_t             tag_mem [SETS];
  logic [CNT_W-1:0] cnt_mem [SETS];

  state_t            state_r;
  logic [SET_W-1:0]  clr_r;
  logic [SET_W-1:0]  set_r;
  logic [TAG_W-1:0]  tag_r;
  logic [TOT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [TOT_W-1:0]  miss_cnt_r, miss_cnt_nxt;
  row_t              rd_tags_r;
  logic [CNT_W-1:0]  rd_cnt_r;

  logic [CNT_W-1:0]  nw, lim, last, start, cnt_nxt;
  logic [MAX_WAYS-1:0] match;
  logic              hit, full_set, shift_on;
  row_t              new_tags;
  logic              mem_we;
  logic [SET_W-1:0]  mem_wa;
  logic [CNT_W-1:0]  mem_wcnt;

  always_comb begin
    if (cfg_ways == '0) begin
      nw = CNT_W'(1);
    end else if (int'(cfg_ways) > MAX_WAYS) begin
      nw = CNT_W'(MAX_WAYS);
    end else begin
      nw = CNT_W'(cfg_ways);
    end
    // valid ways form a prefix of the row; only the first lim are searched
    lim      = (rd_cnt_r < nw) ? rd_cnt_r : nw;
    last     = lim - 1'b1;
    full_set = (rd_cnt_r >= nw);
    for (int j = 0; j < MAX_WAYS; j++) begin
      match[j] = (CNT_W'(j) < lim) && (rd_tags_r[j] == tag_r);
    end
    hit   = |match;
    start = '0;
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (match[j]) begin
        start = CNT_W'(j);
      end
    end
    shift_on = hit || full_set;
    new_tags = rd_tags_r;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (shift_on) begin
        if ((j < MAX_WAYS - 1) && (CNT_W'(j) >= start) && (CNT_W'(j) < last)) begin
          new_tags[j] = rd_tags_r[(j < MAX_WAYS - 1) ? j + 1 : j];
        end
        if (CNT_W'(j) == last) begin
          new_tags[j] = tag_r;
        end
      end else if (CNT_W'(j) == rd_cnt_r) begin
        new_tags[j] = tag_r;
      end
    end
    cnt_nxt      = (!hit && !full_set) ? rd_cnt_r + 1'b1 : rd_cnt_r;
    hit_cnt_nxt  = (hit && (hit_cnt_r != '1)) ? hit_cnt_r + 1'b1 : hit_cnt_r;
    miss_cnt_nxt = (!hit && (miss_cnt_r != '1)) ? miss_cnt_r + 1'b1 : miss_cnt_r;
  end

  assign clearing = (state_r == S_CLEAR);
  assign mid_pop  = (state_r == S_IDLE) && !mid_empty && !res_full;
  assign mem_we   = clearing || (state_r == S_UPD);
  assign mem_wa   = clearing ? clr_r : set_r;
  assign mem_wcnt = clearing ? '0 : cnt_nxt;

  assign res_push     = (state_r == S_UPD);
  assign res_hit      = hit;
  assign res_set      = set_r;
  assign res_tag      = tag_r;
  assign res_hit_tot  = hit_cnt_nxt;
  assign res_miss_tot = miss_cnt_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_wa] <= new_tags;
      cnt_mem[mem_wa] <= mem_wcnt;
    end
    rd_tags_r <= tag_mem[mid_set];
    rd_cnt_r  <= cnt_mem[mid_set];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == SET_W'(SETS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (mid_pop) begin
            set_r   <= mid_set;
            tag_r   <= mid_tag;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          hit_cnt_r  <= hit_cnt_nxt;
          miss_cnt_r <= miss_cnt_nxt;
          state_r    <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result beat pushed into a full queue");
  a_pop_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |=> (state_r == S_UPD)) else $error("popped beat not updated");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !mid_pop) else $error("beat taken during clearing sweep");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (cnt_nxt <= CNT_W'(MAX_WAYS)))
    else $error("valid way count beyond associativity");

endmodule

// ===== sv/set_assoc_cache_lru_lookup_core.sv =====
`timescale 1ns / 1ps
// Top level of the set-associative true-LRU tag lookup.
// Depends on clc_pkg, clc_front, clc_fifo and clc_back.
//
// Each address beat is split into set and tag, queued, then looked up in a
// set memory that holds, per set, the tags in LRU order (way 0 oldest) and
// a count of valid ways. Each lookup is a read-modify-write of one set row,
// read as the beat is popped, then compared, reordered and written back in
// S_UPD; the back end pops the next beat only after that write. After reset
// the block runs a clearing sweep over all 2**MAX_INDEX_BITS sets (1024 at
// the default) that zeroes the valid counts; in_full stays high meanwhile,
// configuration writes are still taken. Results come out through a two-entry
// queue in address order, each with the hit flag, set, tag and the
// saturating hit and miss totals after that access.
// Configuration must only be written while no beat is in flight.
module set_assoc_cache_lru_lookup_core #(
  parameter int MAX_INDEX_BITS = clc_pkg::DEF_MAX_INDEX_BITS,
  parameter int MAX_WAYS       = clc_pkg::DEF_MAX_WAYS,
  localparam int SET_W = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [clc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clc_pkg::CFG_W-1:0]     cfg_wdata,
  // address beats
  input  logic                          in_push,
  input  logic [clc_pkg::ADDR_W-1:0]    in_address,
  output logic                          in_full,
  // result beats
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic                          out_hit,
  output logic [SET_W-1:0]              out_set_index,
  output logic [clc_pkg::TAG_W-1:0]     out_tag_value,
  output logic [clc_pkg::TOT_W-1:0]     out_hit_total,
  output logic [clc_pkg::TOT_W-1:0]     out_miss_total
);
  import clc_pkg::*;

  localparam int MID_W = SET_W + TAG_W;
  localparam int RES_W = 1 + SET_W + TAG_W + 2 * TOT_W;

  cfg_t cfg_r;

  // front end outputs
  logic [SET_W-1:0] fr_set;
  logic [TAG_W-1:0] fr_tag;

  // front/back queue
  logic             mid_push, mid_full, mid_pop, mid_empty;
  logic [MID_W-1:0] mid_dout;

  // back end results
  logic             clearing;
  logic             res_push, res_full, res_hit;
  logic [SET_W-1:0] res_set;
  logic [TAG_W-1:0] res_tag;
  logic [TOT_W-1:0] res_hit_tot, res_miss_tot;
  logic [RES_W-1:0] res_dout;

  // configuration registers; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.index_bits        <= RST_INDEX_BITS;
      cfg_r.block_offset_bits <= RST_OFFSET_BITS;
      cfg_r.ways              <= RST_WAYS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INDEX_BITS:  cfg_r.index_bits        <= cfg_wdata;
        REG_OFFSET_BITS: cfg_r.block_offset_bits <= cfg_wdata;
        REG_WAYS:        cfg_r.ways              <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // hold off input during the clearing sweep
  assign in_full  = mid_full || clearing;
  assign mid_push = in_push && !in_full;

  clc_front #(
    .MAX_INDEX_BITS(MAX_INDEX_BITS)
  ) u_front (
    .address (in_address),
    .cfg     (cfg_r),
    .set_idx (fr_set),
    .tag     (fr_tag)
  );

  clc_fifo #(
    .W(MID_W)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .din   ({fr_set, fr_tag}),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty)
  );

  clc_back #(
    .MAX_INDEX_BITS(MAX_INDEX_BITS),
    .MAX_WAYS      (MAX_WAYS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ways     (cfg_r.ways),
    .mid_empty    (mid_empty),
    .mid_set      (mid_dout[MID_W-1:TAG_W]),
    .mid_tag      (mid_dout[TAG_W-1:0]),
    .mid_pop      (mid_pop),
    .res_full     (res_full),
    .res_push     (res_push),
    .res_hit      (res_hit),
    .res_set      (res_set),
    .res_tag      (res_tag),
    .res_hit_tot  (res_hit_tot),
    .res_miss_tot (res_miss_tot),
    .clearing     (clearing)
  );

  // result queue parts the back end from the consumer
  clc_fifo #(
    .W(RES_W)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   ({res_hit, res_set, res_tag, res_hit_tot, res_miss_tot}),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_dout),
    .empty (out_empty)
  );

  assign out_miss_total = res_dout[TOT_W-1:0];
  assign out_hit_total  = res_dout[2*TOT_W-1:TOT_W];
  assign out_tag_value  = res_dout[2*TOT_W+TAG_W-1:2*TOT_W];
  assign out_set_index  = res_dout[2*TOT_W+TAG_W+SET_W-1:2*TOT_W+TAG_W];
  assign out_hit        = res_dout[RES_W-1];

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for set_assoc_cache_lru_lookup_core: directed table, then
// random register settings with reuse-heavy address streams, each checked against
// a hand-worked result or a local true-LRU predictor. Depends on clc_pkg and the RTL only.
module testbench;
  import clc_pkg::*;

  localparam int SET_BITS     = DEF_MAX_INDEX_BITS;
  localparam int WAY_SLOTS    = DEF_MAX_WAYS;
  localparam int STORE_WORDS  = (1 << SET_BITS) * WAY_SLOTS;
  localparam int RANDOM_BEATS = 1850;
  localparam int PHASES       = 12;
  localparam int CALM_BEATS   = 150;   // tail of the run with no idling
  localparam int LONG_HOLD    = 200;   // receiver hold-off, in cycles
  localparam int HOLD_AFTER   = 500;   // results seen before the long hold-off
  localparam int SETTLE       = 4;     // cycles allowed after the last result

  // index 3 decodes to no register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic                hit;
    logic [SET_BITS-1:0] set_index;
    logic [TAG_W-1:0]    tag_value;
    logic [TOT_W-1:0]    hit_total;
    logic [TOT_W-1:0]    miss_total;
  } lookup_t;

  typedef enum logic { ROW_ACCESS, ROW_WRITE } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     wdata;
    logic [ADDR_W-1:0]    addr;
    logic                 known;   // want holds a hand-worked result
    lookup_t              want;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input known from time zero
  // ---------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_push = 1'b0;
  logic [ADDR_W-1:0]    in_address = '0;
  logic                 in_full;
  logic                 out_pop = 1'b0;
  logic                 out_empty;
  logic                 out_hit;
  logic [SET_BITS-1:0]  out_set_index;
  logic [TAG_W-1:0]     out_tag_value;
  logic [TOT_W-1:0]     out_hit_total;
  logic [TOT_W-1:0]     out_miss_total;

  set_assoc_cache_lru_lookup_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_address     (in_address),
    .in_full        (in_full),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_hit        (out_hit),
    .out_set_index  (out_set_index),
    .out_tag_value  (out_tag_value),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: a shadow of the tag/valid rows, the counters and the registers.
  // Rows are kept LRU first; valid bits only ever grow as a prefix of a row.
  // ---------------------------------------------------------------------------
  logic [TAG_W-1:0] lru_tag   [STORE_WORDS];
  bit               lru_valid [STORE_WORDS];
  logic [TOT_W-1:0] hit_sat  = '0;
  logic [TOT_W-1:0] miss_sat = '0;
  cfg_t             shadow_cfg = '{index_bits: RST_INDEX_BITS,
                                   block_offset_bits: RST_OFFSET_BITS,
                                   ways: RST_WAYS};

  lookup_t expected_lookups [$];

  // clamped register values as the lookup sees them
  function automatic int unsigned used_index_bits();
    return (shadow_cfg.index_bits > SET_BITS) ? SET_BITS : shadow_cfg.index_bits;
  endfunction

  function automatic int unsigned used_offset_bits();
    if (shadow_cfg.block_offset_bits < MIN_OFFSET_BITS) return MIN_OFFSET_BITS;
    if (shadow_cfg.block_offset_bits > MAX_OFFSET_BITS) return MAX_OFFSET_BITS;
    return shadow_cfg.block_offset_bits;
  endfunction

  function automatic int unsigned used_ways();
    if (shadow_cfg.ways == 0) return 1;
    if (shadow_cfg.ways > WAY_SLOTS) return WAY_SLOTS;
    return shadow_cfg.ways;
  endfunction

  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    case (idx)
      REG_INDEX_BITS:  shadow_cfg.index_bits = v;
      REG_OFFSET_BITS: shadow_cfg.block_offset_bits = v;
      REG_WAYS:        shadow_cfg.ways = v;
      default: ;
    endcase
  endfunction

  function automatic lookup_t predict_lookup(logic [ADDR_W-1:0] a);
    int unsigned ib, ob, nw, s, base, i, hw;
    logic [ADDR_W-1:0] shifted;
    logic [TAG_W-1:0] t;
    bit found;
    lookup_t r;
    ib = used_index_bits();
    ob = used_offset_bits();
    nw = used_ways();
    s = (a >> ob) & ((32'd1 << ib) - 1);
    shifted = a >> (ib + ob);
    t = shifted[TAG_W-1:0];
    base = s * WAY_SLOTS;
    found = 1'b0;
    hw = 0;
    for (i = 0; i < nw; i++) begin
      if (!lru_valid[base + i]) break;
      if (lru_tag[base + i] == t) begin
        found = 1'b1;
        hw = i;
        break;
      end
    end
    if (found) begin
      if (hit_sat != '1) hit_sat++;
      // slide the younger valid ways down, hit tag lands as most recent
      i = hw;
      while (i + 1 < nw && lru_valid[base + i + 1]) begin
        lru_tag[base + i] = lru_tag[base + i + 1];
        i++;
      end
      lru_tag[base + i] = t;
    end else begin
      if (miss_sat != '1) miss_sat++;
      if (!lru_valid[base + nw - 1]) begin
        for (i = 0; i < nw; i++) begin
          if (!lru_valid[base + i]) begin
            lru_tag[base + i] = t;
            lru_valid[base + i] = 1'b1;
            break;
          end
        end
      end else begin
        // full row: drop the LRU way, append at the top
        for (i = 0; i + 1 < nw; i++) lru_tag[base + i] = lru_tag[base + i + 1];
        lru_tag[base + nw - 1] = t;
      end
    end
    r.hit        = found;
    r.set_index  = s[SET_BITS-1:0];
    r.tag_value  = t;
    r.hit_total  = hit_sat;
    r.miss_total = miss_sat;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: pop with random stall bursts, plus one long hold-off so the
  // block backs up and raises in_full while the sender keeps offering.
  // ---------------------------------------------------------------------------
  bit          calm = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned results_seen = 0;
  int unsigned hits_seen = 0;
  int unsigned mismatches = 0;
  int unsigned strays = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left != 0) begin
      out_pop   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
      out_pop        <= 1'b0;
      hold_left      <= LONG_HOLD - 1;
      long_hold_done <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_pop   <= 1'b0;
      hold_left <= $urandom_range(0, 16);
    end else begin
      out_pop <= 1'b1;
    end
  end

  // checker: every popped beat against the oldest expectation
  always @(posedge clk) begin
    lookup_t got, want;
    if (rst_n && out_pop && !out_empty) begin
      got = '{hit: out_hit, set_index: out_set_index, tag_value: out_tag_value,
              hit_total: out_hit_total, miss_total: out_miss_total};
      results_seen <= results_seen + 1;
      if (out_hit) hits_seen <= hits_seen + 1;
      if (expected_lookups.size() == 0) begin
        strays <= strays + 1;
        $display("%0t: result beat with nothing expected (hit %0b set %0d tag %h)",
                 $realtime, got.hit, got.set_index, got.tag_value);
      end else begin
        want = expected_lookups.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("%0t: mismatch  hit %0b/%0b  set %0d/%0d  tag %h/%h  (expected/actual)",
                     $realtime, want.hit, got.hit, want.set_index, got.set_index,
                     want.tag_value, got.tag_value);
            $display("    hits %0d/%0d  misses %0d/%0d  (expected/actual)",
                     want.hit_total, got.hit_total, want.miss_total, got.miss_total);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Address side
  // ---------------------------------------------------------------------------
  int unsigned lookups_sent = 0;
  int unsigned settings_used = 0;

  // offer one address beat, hold it until taken, then log what it should give
  task automatic send_address(input logic [ADDR_W-1:0] a, input logic known,
                              input lookup_t want);
    lookup_t predicted;
    in_push    <= 1'b1;
    in_address <= a;
    do @(posedge clk); while (in_full);
    predicted = predict_lookup(a);
    expected_lookups.push_back(known ? want : predicted);
    lookups_sent++;
  endtask

  // stop offering and wait for the block to run dry
  task automatic drain();
    in_push <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_write(idx, v);
    @(posedge clk);
  endtask

  // row builders for the directed table
  function automatic stim_row_t acc(logic [ADDR_W-1:0] a);
    return '{kind: ROW_ACCESS, reg_idx: '0, wdata: '0, addr: a, known: 1'b0, want: '0};
  endfunction

  function automatic stim_row_t acc_known(logic [ADDR_W-1:0] a, logic h,
                                          logic [SET_BITS-1:0] s, logic [TAG_W-1:0] t,
                                          logic [TOT_W-1:0] nh, logic [TOT_W-1:0] nm);
    return '{kind: ROW_ACCESS, reg_idx: '0, wdata: '0, addr: a, known: 1'b1,
             want: '{hit: h, set_index: s, tag_value: t, hit_total: nh, miss_total: nm}};
  endfunction

  function automatic stim_row_t wr(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    return '{kind: ROW_WRITE, reg_idx: idx, wdata: v, addr: '0, known: 1'b0, want: '0};
  endfunction

  initial begin
    stim_row_t   directed_rows [$];
    int unsigned ib, ob, nw, n_sets, n_tags, phase_beats, idle_odds, k, p, j;
    int unsigned hot_sets [4];
    logic [ADDR_W-1:0] hot_tags [12];
    logic [ADDR_W-1:0] a;
    logic [CFG_W-1:0] r_ib, r_ob, r_w;
    int unsigned random_done;

    for (k = 0; k < STORE_WORDS; k++) begin
      lru_valid[k] = 1'b0;
      lru_tag[k]   = '0;
    end

    // Reset settings: 1024 sets, word blocks, direct mapped; the first rows
    // are easy to work by hand. Then a 4-way row is filled, reordered and
    // evicted; then the clamped register extremes and the unused index.
    directed_rows = '{
      acc_known(32'h0000_0000, 1'b0, 10'd0,    30'h0_0000, 32'd0, 32'd1),
      acc_known(32'h0000_0003, 1'b1, 10'd0,    30'h0_0000, 32'd1, 32'd1),
      acc_known(32'hFFFF_FFFF, 1'b0, 10'd1023, 30'hF_FFFF, 32'd1, 32'd2),
      acc_known(32'h0000_1000, 1'b0, 10'd0,    30'h0_0001, 32'd1, 32'd3),
      acc_known(32'h0000_0000, 1'b0, 10'd0,    30'h0_0000, 32'd1, 32'd4),
      acc_known(32'hFFFF_FFFC, 1'b1, 10'd1023, 30'hF_FFFF, 32'd2, 32'd4),
      wr(REG_WAYS, 4'd4), wr(REG_INDEX_BITS, 4'd2), wr(REG_OFFSET_BITS, 4'd4),
      acc(32'h0000_0050), acc(32'h0000_0090), acc(32'h0000_00D0),
      acc(32'h0000_0050),                    // hit on the LRU way
      acc(32'h0000_0110),                    // fills the last free way
      acc(32'h0000_0150),                    // full row, oldest dropped
      acc(32'h0000_0090),                    // the dropped tag misses
      acc(32'h0000_00DF),                    // evicted by the miss before, misses
      wr(REG_WAYS, 4'd0), wr(REG_INDEX_BITS, 4'd15), wr(REG_OFFSET_BITS, 4'd0),
      acc(32'h0000_0000), acc(32'h8000_0000),
      wr(REG_INDEX_BITS, 4'd0), wr(REG_OFFSET_BITS, 4'd15), wr(REG_WAYS, 4'd15),
      acc(32'hFFFF_FFFF), acc(32'h0000_00FF), acc(32'hFFFF_FF00),
      wr(REG_SPARE, 4'hF),
      acc(32'h0000_0000)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; register rows only once the block is dry
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        drain();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].wdata);
        settings_used++;
      end else begin
        send_address(directed_rows[i].addr, directed_rows[i].known, directed_rows[i].want);
      end
    end

    // Random phases. Each picks a setting (extremes first), a few hot sets
    // and a tag pool of up to three tags beyond the ways in use, so rows fill,
    // hit at every LRU depth and thrash; about one beat in five is noise.
    random_done = 0;
    for (p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       begin r_ib = 4'd0;  r_ob = 4'd2;  r_w = 4'd8;  end
        1:       begin r_ib = 4'd10; r_ob = 4'd8;  r_w = 4'd1;  end
        2:       begin r_ib = 4'd15; r_ob = 4'd15; r_w = 4'd15; end
        3:       begin r_ib = 4'd0;  r_ob = 4'd0;  r_w = 4'd0;  end
        default: begin
          r_ib = CFG_W'($urandom_range(0, 15));
          r_ob = CFG_W'($urandom_range(0, 15));
          r_w  = CFG_W'($urandom_range(0, 15));
        end
      endcase
      write_reg(REG_INDEX_BITS, r_ib);
      write_reg(REG_OFFSET_BITS, r_ob);
      write_reg(REG_WAYS, r_w);
      settings_used++;

      ib = used_index_bits();
      ob = used_offset_bits();
      nw = used_ways();
      n_sets = $urandom_range(1, 4);
      n_tags = nw + $urandom_range(0, 3);
      for (j = 0; j < n_sets; j++) hot_sets[j] = $urandom() & ((32'd1 << ib) - 1);
      for (j = 0; j < n_tags; j++) hot_tags[j] = $urandom();
      idle_odds   = $urandom_range(0, 3);   // 0: no sender gaps this phase
      phase_beats = (p == PHASES - 1) ? RANDOM_BEATS - random_done
                                      : RANDOM_BEATS / PHASES;

      for (j = 0; j < phase_beats; j++) begin
        if (random_done >= RANDOM_BEATS - CALM_BEATS) calm = 1'b1;
        if (!calm && idle_odds != 0 && $urandom_range(0, 3 * idle_odds) == 0) begin
          in_push <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        if ($urandom_range(0, 9) < 2) begin
          a = $urandom();
        end else begin
          a = (hot_tags[$urandom_range(0, n_tags - 1)] << (ib + ob))
            | (ADDR_W'(hot_sets[$urandom_range(0, n_sets - 1)]) << ob)
            | ($urandom() & ((32'd1 << ob) - 1));
        end
        send_address(a, 1'b0, '0);
        random_done++;
      end
    end

    drain();
    repeat (20) @(posedge clk);

    $display("Covered %0d lookups (%0d hits) across %0d register settings,",
             lookups_sent, hits_seen, settings_used);
    $display("including clamped extremes, LRU reorder, eviction and a backed-up output.");
    if (mismatches == 0 && strays == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d unexpected beats", mismatches, strays);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog: well beyond the slowest legal run, clearing sweep included
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
